FILE: sv/complex_arith_unit_core_macros.svh
// Assertion helpers for the complex arithmetic unit.
`ifndef COMPLEX_ARITH_UNIT_CORE_MACROS_SVH
`define COMPLEX_ARITH_UNIT_CORE_MACROS_SVH

`define CAU_CHECK_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("complex_arith_unit_core: same-cycle check failed");

`define CAU_CHECK_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("complex_arith_unit_core: next-cycle check failed");

`endif

FILE: sv/cau_pkg.sv
`default_nettype none

package cau_pkg;

  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int GUARD_BITS = WORD_BITS - 1;
  localparam int ACT_BITS   = 3;
  localparam int STAT_BITS  = 2;
  localparam int WIDE_BITS  = 2 * WORD_BITS + 1;
  localparam int QUO_BITS   = WORD_BITS + 1 + FRAC_BITS;

  localparam logic [ACT_BITS-1:0] ACT_ADD  = 3'd0;
  localparam logic [ACT_BITS-1:0] ACT_SUB  = 3'd1;
  localparam logic [ACT_BITS-1:0] ACT_MUL  = 3'd2;
  localparam logic [ACT_BITS-1:0] ACT_DIV  = 3'd3;
  localparam logic [ACT_BITS-1:0] ACT_CONJ = 3'd4;

  localparam logic [STAT_BITS-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_SAT  = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_DIV0 = 2'd2;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [WORD_BITS-1:0]        mag_t;
  typedef logic signed [WIDE_BITS-1:0] wide_t;
  typedef logic signed [WORD_BITS+1:0] nwide_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic [ACT_BITS-1:0] action;
    word_t               a_re;
    word_t               a_im;
    word_t               b_re;
    word_t               b_im;
  } cau_req_t;

  typedef struct packed {
    word_t                z_re;
    word_t                z_im;
    logic [STAT_BITS-1:0] status;
  } cau_rsp_t;

  typedef struct packed {
    word_t v;
    logic  sat;
  } sat_t;

  typedef struct packed {
    cau_req_t                      req;
    logic signed [2*WORD_BITS-1:0] p_rr;
    logic signed [2*WORD_BITS-1:0] p_ii;
    logic signed [2*WORD_BITS-1:0] p_ri;
    logic signed [2*WORD_BITS-1:0] p_ir;
  } prod_t;

  typedef struct packed {
    cau_rsp_t early;
    logic     is_div;
    logic     first;
    logic     w_neg;
    logic     big_neg;
    mag_t     bm;
    mag_t     sm;
    mag_t     am_re;
    mag_t     am_im;
    word_t    a_re;
    word_t    a_im;
    mag_t     rem;
    mag_t     quo;
  } wdiv_t;

  typedef struct packed {
    cau_rsp_t               early;
    logic                   is_div;
    logic                   first;
    logic                   w_neg;
    logic                   big_neg;
    mag_t                   bm;
    word_t                  a_re;
    word_t                  a_im;
    logic [2*WORD_BITS-1:0] ps;
    logic [2*WORD_BITS-1:0] pi;
    logic [2*WORD_BITS-1:0] pr;
  } mprod_t;

  typedef struct packed {
    cau_rsp_t         early;
    logic             is_div;
    logic             big_neg;
    logic [WORD_BITS:0] dv;
    nwide_t           nr;
    nwide_t           ni;
  } nsum_t;

  typedef struct packed {
    cau_rsp_t            early;
    logic                is_div;
    logic                neg_re;
    logic                neg_im;
    logic [WORD_BITS:0]  dv;
    logic [QUO_BITS-1:0] n_re;
    logic [QUO_BITS-1:0] n_im;
    logic [QUO_BITS-1:0] q_re;
    logic [QUO_BITS-1:0] q_im;
    mag_t                r_re;
    mag_t                r_im;
  } zdiv_t;

endpackage

`default_nettype wire

FILE: sv/complex_arith_unit_core.sv
// Channel   Valid      Stall      Payload
// request   in_valid   in_stall   in_data  (cau_req_t)
// result    out_valid  out_stall  out_data (cau_rsp_t)
//
// Every operation passes through the 32 one-bit stages of the pivot-ratio
// divider and the 49 one-bit stages of the final quotient dividers. A new
// request is accepted every cycle unless a result waits under out_stall.
// Reset clears only the valid bits of the pipeline and the output register.
// While a result waits under out_stall the whole pipeline holds.
`default_nettype none
`include "complex_arith_unit_core_macros.svh"

module complex_arith_unit_core
  import cau_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire cau_req_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output cau_rsp_t      out_data
);

  function automatic sat_t sat_word(input wide_t x);
    sat_t s;
    if (x > wide_t'(WORD_MAX)) begin
      s.v = WORD_MAX;
      s.sat = 1'b1;
    end else if (x < wide_t'(WORD_MIN)) begin
      s.v = WORD_MIN;
      s.sat = 1'b1;
    end else begin
      s.v = x[WORD_BITS-1:0];
      s.sat = 1'b0;
    end
    return s;
  endfunction

  function automatic wide_t shr_tz(input wide_t x);
    wide_t bias;
    bias = '0;
    if (x[WIDE_BITS-1]) begin
      bias[FRAC_BITS-1:0] = '1;
    end
    return (x + bias) >>> FRAC_BITS;
  endfunction

  function automatic sat_t div_out(input logic [QUO_BITS-1:0] q, input logic neg);
    sat_t s;
    if (neg) begin
      if ((|q[QUO_BITS-1:WORD_BITS]) || (q[WORD_BITS-1] && (|q[WORD_BITS-2:0]))) begin
        s.v = WORD_MIN;
        s.sat = 1'b1;
      end else begin
        s.v = word_t'(mag_t'(0) - q[WORD_BITS-1:0]);
        s.sat = 1'b0;
      end
    end else begin
      if (|q[QUO_BITS-1:WORD_BITS-1]) begin
        s.v = WORD_MAX;
        s.sat = 1'b1;
      end else begin
        s.v = word_t'(q[WORD_BITS-1:0]);
        s.sat = 1'b0;
      end
    end
    return s;
  endfunction

  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  cau_req_t req_r;
  logic     v1_r;
  prod_t    pk_r;
  logic     v2_r;

  wdiv_t wd_r [0:WORD_BITS];
  logic  wv_r [0:WORD_BITS];
  mprod_t m1_r;
  logic   m1v_r;
  nsum_t  m2_r;
  logic   m2v_r;
  zdiv_t zd_r [0:QUO_BITS];
  logic  zv_r [0:QUO_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      wv_r[0] <= 1'b0;
      m1v_r <= 1'b0;
      m2v_r <= 1'b0;
      zv_r[0] <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      wv_r[0] <= v2_r;
      m1v_r <= wv_r[WORD_BITS];
      m2v_r <= m1v_r;
      zv_r[0] <= m2v_r;
    end
  end

  prod_t pk_nxt;
  always_comb begin
    pk_nxt.req = req_r;
    pk_nxt.p_rr = req_r.a_re * req_r.b_re;
    pk_nxt.p_ii = req_r.a_im * req_r.b_im;
    pk_nxt.p_ri = req_r.a_re * req_r.b_im;
    pk_nxt.p_ir = req_r.a_im * req_r.b_re;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req_r <= in_data;
      pk_r <= pk_nxt;
    end
  end

  wdiv_t wd0_nxt;
  always_comb begin
    cau_req_t q;
    sat_t     sr;
    sat_t     si;
    mag_t     bm_re;
    mag_t     bm_im;
    logic     div0;
    q = pk_r.req;
    sr = '0;
    si = '0;
    bm_re = q.b_re[WORD_BITS-1] ? mag_t'(-q.b_re) : mag_t'(q.b_re);
    bm_im = q.b_im[WORD_BITS-1] ? mag_t'(-q.b_im) : mag_t'(q.b_im);
    div0 = (bm_re == '0) && (bm_im == '0);
    wd0_nxt.early = '0;
    case (q.action)
      ACT_ADD: begin
        sr = sat_word(wide_t'(q.a_re) + wide_t'(q.b_re));
        si = sat_word(wide_t'(q.a_im) + wide_t'(q.b_im));
      end
      ACT_SUB: begin
        sr = sat_word(wide_t'(q.a_re) - wide_t'(q.b_re));
        si = sat_word(wide_t'(q.a_im) - wide_t'(q.b_im));
      end
      ACT_MUL: begin
        sr = sat_word(shr_tz(wide_t'(pk_r.p_rr) - wide_t'(pk_r.p_ii)));
        si = sat_word(shr_tz(wide_t'(pk_r.p_ri) + wide_t'(pk_r.p_ir)));
      end
      ACT_CONJ: begin
        sr = sat_word(wide_t'(q.a_re));
        si = sat_word(-wide_t'(q.a_im));
      end
      default: begin
        sr = '0;
        si = '0;
      end
    endcase
    wd0_nxt.early.z_re = sr.v;
    wd0_nxt.early.z_im = si.v;
    wd0_nxt.early.status = (sr.sat || si.sat) ? ST_SAT : ST_OK;
    if (q.action == ACT_DIV && div0) begin
      wd0_nxt.early.status = ST_DIV0;
    end
    wd0_nxt.is_div = (q.action == ACT_DIV) && !div0;
    wd0_nxt.first = bm_re >= bm_im;
    wd0_nxt.bm = wd0_nxt.first ? bm_re : bm_im;
    wd0_nxt.sm = wd0_nxt.first ? bm_im : bm_re;
    wd0_nxt.big_neg = wd0_nxt.first ? q.b_re[WORD_BITS-1] : q.b_im[WORD_BITS-1];
    wd0_nxt.w_neg = q.b_re[WORD_BITS-1] ^ q.b_im[WORD_BITS-1];
    wd0_nxt.am_re = q.a_re[WORD_BITS-1] ? mag_t'(-q.a_re) : mag_t'(q.a_re);
    wd0_nxt.am_im = q.a_im[WORD_BITS-1] ? mag_t'(-q.a_im) : mag_t'(q.a_im);
    wd0_nxt.a_re = q.a_re;
    wd0_nxt.a_im = q.a_im;
    wd0_nxt.rem = wd0_nxt.sm;
    wd0_nxt.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wd_r[0] <= wd0_nxt;
    end
  end

  for (genvar k = 1; k <= WORD_BITS; k++) begin : g_wdiv
    wdiv_t              wd_nxt;
    logic [WORD_BITS:0] t;
    logic               ge;
    always_comb begin
      t = (k == 1) ? {1'b0, wd_r[k-1].rem} : {wd_r[k-1].rem, 1'b0};
      ge = t >= {1'b0, wd_r[k-1].bm};
      wd_nxt = wd_r[k-1];
      wd_nxt.rem = ge ? mag_t'(t - {1'b0, wd_r[k-1].bm}) : mag_t'(t);
      wd_nxt.quo = {wd_r[k-1].quo[WORD_BITS-2:0], ge};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        wv_r[k] <= 1'b0;
      end else if (en) begin
        wv_r[k] <= wv_r[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        wd_r[k] <= wd_nxt;
      end
    end
  end

  mprod_t m1_nxt;
  always_comb begin
    wdiv_t s;
    s = wd_r[WORD_BITS];
    m1_nxt.early = s.early;
    m1_nxt.is_div = s.is_div;
    m1_nxt.first = s.first;
    m1_nxt.w_neg = s.w_neg;
    m1_nxt.big_neg = s.big_neg;
    m1_nxt.bm = s.bm;
    m1_nxt.a_re = s.a_re;
    m1_nxt.a_im = s.a_im;
    m1_nxt.ps = s.sm * s.quo;
    m1_nxt.pi = s.am_im * s.quo;
    m1_nxt.pr = s.am_re * s.quo;
  end

  nsum_t m2_nxt;
  always_comb begin
    mag_t   ts;
    mag_t   ti;
    mag_t   tr;
    nwide_t ti_s;
    nwide_t tr_s;
    nwide_t ar_s;
    nwide_t ai_s;
    ts = mag_t'(m1_r.ps >> GUARD_BITS);
    ti = mag_t'(m1_r.pi >> GUARD_BITS);
    tr = mag_t'(m1_r.pr >> GUARD_BITS);
    ti_s = (m1_r.a_im[WORD_BITS-1] ^ m1_r.w_neg) ? -nwide_t'(ti) : nwide_t'(ti);
    tr_s = (m1_r.a_re[WORD_BITS-1] ^ m1_r.w_neg) ? -nwide_t'(tr) : nwide_t'(tr);
    ar_s = nwide_t'(m1_r.a_re);
    ai_s = nwide_t'(m1_r.a_im);
    m2_nxt.early = m1_r.early;
    m2_nxt.is_div = m1_r.is_div;
    m2_nxt.big_neg = m1_r.big_neg;
    m2_nxt.dv = {1'b0, m1_r.bm} + {1'b0, ts};
    if (m1_r.first) begin
      m2_nxt.nr = ar_s + ti_s;
      m2_nxt.ni = ai_s - tr_s;
    end else begin
      m2_nxt.nr = tr_s + ai_s;
      m2_nxt.ni = ti_s - ar_s;
    end
  end

  zdiv_t zd0_nxt;
  always_comb begin
    nwide_t nm_re;
    nwide_t nm_im;
    nm_re = m2_r.nr[WORD_BITS+1] ? -m2_r.nr : m2_r.nr;
    nm_im = m2_r.ni[WORD_BITS+1] ? -m2_r.ni : m2_r.ni;
    zd0_nxt.early = m2_r.early;
    zd0_nxt.is_div = m2_r.is_div;
    zd0_nxt.neg_re = m2_r.nr[WORD_BITS+1] ^ m2_r.big_neg;
    zd0_nxt.neg_im = m2_r.ni[WORD_BITS+1] ^ m2_r.big_neg;
    zd0_nxt.dv = m2_r.dv;
    zd0_nxt.n_re = {nm_re[WORD_BITS:0], {FRAC_BITS{1'b0}}};
    zd0_nxt.n_im = {nm_im[WORD_BITS:0], {FRAC_BITS{1'b0}}};
    zd0_nxt.q_re = '0;
    zd0_nxt.q_im = '0;
    zd0_nxt.r_re = '0;
    zd0_nxt.r_im = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r <= m1_nxt;
      m2_r <= m2_nxt;
      zd_r[0] <= zd0_nxt;
    end
  end

  for (genvar k = 1; k <= QUO_BITS; k++) begin : g_zdiv
    zdiv_t              zd_nxt;
    logic [WORD_BITS:0] t_re;
    logic [WORD_BITS:0] t_im;
    logic               ge_re;
    logic               ge_im;
    always_comb begin
      t_re = {zd_r[k-1].r_re, zd_r[k-1].n_re[QUO_BITS-1]};
      t_im = {zd_r[k-1].r_im, zd_r[k-1].n_im[QUO_BITS-1]};
      ge_re = t_re >= zd_r[k-1].dv;
      ge_im = t_im >= zd_r[k-1].dv;
      zd_nxt = zd_r[k-1];
      zd_nxt.r_re = ge_re ? mag_t'(t_re - zd_r[k-1].dv) : t_re[WORD_BITS-1:0];
      zd_nxt.r_im = ge_im ? mag_t'(t_im - zd_r[k-1].dv) : t_im[WORD_BITS-1:0];
      zd_nxt.n_re = {zd_r[k-1].n_re[QUO_BITS-2:0], 1'b0};
      zd_nxt.n_im = {zd_r[k-1].n_im[QUO_BITS-2:0], 1'b0};
      zd_nxt.q_re = {zd_r[k-1].q_re[QUO_BITS-2:0], ge_re};
      zd_nxt.q_im = {zd_r[k-1].q_im[QUO_BITS-2:0], ge_im};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        zv_r[k] <= 1'b0;
      end else if (en) begin
        zv_r[k] <= zv_r[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        zd_r[k] <= zd_nxt;
      end
    end
  end

  cau_rsp_t rsp_nxt;
  always_comb begin
    sat_t dr;
    sat_t di;
    dr = div_out(zd_r[QUO_BITS].q_re, zd_r[QUO_BITS].neg_re);
    di = div_out(zd_r[QUO_BITS].q_im, zd_r[QUO_BITS].neg_im);
    if (zd_r[QUO_BITS].is_div) begin
      rsp_nxt.z_re = dr.v;
      rsp_nxt.z_im = di.v;
      rsp_nxt.status = (dr.sat || di.sat) ? ST_SAT : ST_OK;
    end else begin
      rsp_nxt = zd_r[QUO_BITS].early;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= zv_r[QUO_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= rsp_nxt;
    end
  end

  `CAU_CHECK_NOW(a_div0_zero, out_valid && out_data.status == ST_DIV0, out_data.z_re == '0 && out_data.z_im == '0)
  `CAU_CHECK_NOW(a_sat_limit, out_valid && out_data.status == ST_SAT, out_data.z_re == WORD_MAX || out_data.z_re == WORD_MIN || out_data.z_im == WORD_MAX || out_data.z_im == WORD_MIN)
  `CAU_CHECK_NEXT(a_pipe_hold, out_valid && out_stall, $stable(zv_r[QUO_BITS]) && $stable(wv_r[WORD_BITS]) && $stable(v1_r))

endmodule

`default_nettype wire

FILE: test/complex_arith_unit_core_test.sv
`timescale 1ns / 100ps
`default_nettype none

module complex_arith_unit_core_test
  import cau_pkg::*;
;
  localparam int LATENCY = 88;
  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 600;
  localparam int DIRECTED_ITEMS = 24;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  cau_req_t in_data;
  logic out_valid;
  logic out_stall;
  cau_rsp_t out_data;

  cau_rsp_t result_queue[$];
  int mismatches;
  bit failed;
  bit stimulus_done;
  bit hold_off;
  int idle_cycles;

  cau_req_t directed_req[DIRECTED_ITEMS];
  cau_rsp_t directed_rsp[DIRECTED_ITEMS];
  bit directed_known[DIRECTED_ITEMS];

  complex_arith_unit_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic word_t saturate(input logic signed [199:0] v, inout bit sat);
    if (v > 200'sd2147483647) begin
      sat = 1'b1;
      return WORD_MAX;
    end
    if (v < -200'sd2147483648) begin
      sat = 1'b1;
      return WORD_MIN;
    end
    return word_t'(v);
  endfunction

  // Signed division and shifts truncating toward zero.
  function automatic logic signed [199:0] tdiv(input logic signed [199:0] n,
                                               input logic signed [199:0] d);
    logic [199:0] q;
    q = (n < 0 ? -n : n) / (d < 0 ? -d : d);
    return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
  endfunction

  function automatic cau_rsp_t complex_result(input cau_req_t r);
    logic signed [199:0] ar, ai, br, bi, zr, zi, w, d, nr, ni, g;
    bit sat;
    cau_rsp_t res;
    ar = r.a_re; ai = r.a_im; br = r.b_re; bi = r.b_im;
    g = 200'sd1 <<< GUARD_BITS;
    zr = 0; zi = 0; sat = 1'b0;
    case (r.action)
      ACT_ADD: begin
        zr = ar + br; zi = ai + bi;
      end
      ACT_SUB: begin
        zr = ar - br; zi = ai - bi;
      end
      ACT_MUL: begin
        zr = tdiv(ar * br - ai * bi, 200'sd1 <<< FRAC_BITS);
        zi = tdiv(ar * bi + ai * br, 200'sd1 <<< FRAC_BITS);
      end
      ACT_DIV: begin
        if (br == 0 && bi == 0) begin
          res.z_re = '0; res.z_im = '0; res.status = ST_DIV0;
          return res;
        end
        if ((br < 0 ? -br : br) >= (bi < 0 ? -bi : bi)) begin
          w = tdiv(bi * g, br);
          d = br + tdiv(bi * w, g);
          nr = ar + tdiv(ai * w, g);
          ni = ai - tdiv(ar * w, g);
        end else begin
          w = tdiv(br * g, bi);
          d = bi + tdiv(br * w, g);
          nr = tdiv(ar * w, g) + ai;
          ni = tdiv(ai * w, g) - ar;
        end
        zr = tdiv(nr * (200'sd1 <<< FRAC_BITS), d);
        zi = tdiv(ni * (200'sd1 <<< FRAC_BITS), d);
      end
      ACT_CONJ: begin
        zr = ar; zi = -ai;
      end
      default: ;
    endcase
    res.z_re = saturate(zr, sat);
    res.z_im = saturate(zi, sat);
    res.status = sat ? ST_SAT : ST_OK;
    return res;
  endfunction

  function automatic word_t random_word();
    case ($urandom_range(0, 7))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return word_t'($urandom_range(0, 3));
      3: return word_t'($signed($urandom_range(0, 2 * 65536)) - 65536);
      4: return word_t'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic cau_req_t random_request();
    cau_req_t r;
    r.action = ($urandom_range(0, 19) == 0) ? ACT_BITS'($urandom_range(5, 7))
                                            : ACT_BITS'($urandom_range(0, 4));
    r.a_re = random_word();
    r.a_im = random_word();
    r.b_re = random_word();
    r.b_im = random_word();
    if (r.action == ACT_DIV && $urandom_range(0, 9) == 0) begin
      r.b_re = '0;
      r.b_im = '0;
    end
    return r;
  endfunction

  function automatic cau_req_t req(input logic [ACT_BITS-1:0] act, input word_t a_re,
                                   input word_t a_im, input word_t b_re, input word_t b_im);
    cau_req_t r;
    r.action = act; r.a_re = a_re; r.a_im = a_im; r.b_re = b_re; r.b_im = b_im;
    return r;
  endfunction

  function automatic cau_rsp_t rsp(input word_t z_re, input word_t z_im,
                                   input logic [STAT_BITS-1:0] status);
    cau_rsp_t r;
    r.z_re = z_re; r.z_im = z_im; r.status = status;
    return r;
  endfunction

  task automatic build_table();
    int k;
    for (k = 0; k < DIRECTED_ITEMS; k++) directed_known[k] = 1'b0;
    directed_req[0] = req(ACT_ADD, 32'sd1, 32'sd2, 32'sd3, 32'sd4);
    directed_rsp[0] = rsp(32'sd4, 32'sd6, ST_OK); directed_known[0] = 1'b1;
    directed_req[1] = req(ACT_ADD, WORD_MAX, WORD_MIN, 32'sd1, -32'sd1);
    directed_rsp[1] = rsp(WORD_MAX, WORD_MIN, ST_SAT); directed_known[1] = 1'b1;
    directed_req[2] = req(ACT_SUB, WORD_MIN, WORD_MAX, 32'sd1, -32'sd1);
    directed_rsp[2] = rsp(WORD_MIN, WORD_MAX, ST_SAT); directed_known[2] = 1'b1;
    directed_req[3] = req(ACT_SUB, 32'sd5, 32'sd5, 32'sd5, 32'sd5);
    directed_rsp[3] = rsp(32'sd0, 32'sd0, ST_OK); directed_known[3] = 1'b1;
    directed_req[4] = req(ACT_MUL, 32'sh10000, 32'sd0, 32'sh10000, 32'sd0);
    directed_rsp[4] = rsp(32'sh10000, 32'sd0, ST_OK); directed_known[4] = 1'b1;
    directed_req[5] = req(ACT_MUL, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
    directed_req[6] = req(ACT_MUL, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    directed_req[7] = req(ACT_MUL, -32'sd1, 32'sd1, 32'sd1, 32'sd1);
    directed_req[8] = req(ACT_DIV, 32'sd7, -32'sd7, 32'sd0, 32'sd0);
    directed_rsp[8] = rsp(32'sd0, 32'sd0, ST_DIV0); directed_known[8] = 1'b1;
    directed_req[9] = req(ACT_DIV, 32'sh10000, 32'sd0, 32'sh10000, 32'sd0);
    directed_rsp[9] = rsp(32'sh10000, 32'sd0, ST_OK); directed_known[9] = 1'b1;
    directed_req[10] = req(ACT_DIV, 32'sh30000, 32'sh10000, 32'sh10000, 32'sh20000);
    directed_req[11] = req(ACT_DIV, WORD_MAX, WORD_MIN, 32'sd1, 32'sd0);
    directed_req[12] = req(ACT_DIV, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    directed_req[13] = req(ACT_DIV, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN);
    directed_req[14] = req(ACT_DIV, 32'sd3, -32'sd9, -32'sd1, 32'sd1);
    directed_req[15] = req(ACT_DIV, -32'sh10000, 32'sh8000, 32'sd0, -32'sh10000);
    directed_req[16] = req(ACT_CONJ, 32'sd9, WORD_MIN, 32'sd3, 32'sd4);
    directed_rsp[16] = rsp(32'sd9, WORD_MAX, ST_SAT); directed_known[16] = 1'b1;
    directed_req[17] = req(ACT_CONJ, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN);
    directed_rsp[17] = rsp(WORD_MIN, -WORD_MAX, ST_OK); directed_known[17] = 1'b1;
    directed_req[18] = req(ACT_CONJ, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    directed_rsp[18] = rsp(32'sd0, 32'sd0, ST_OK); directed_known[18] = 1'b1;
    directed_req[19] = req(3'd5, 32'sd1, 32'sd2, 32'sd3, 32'sd4);
    directed_rsp[19] = rsp(32'sd0, 32'sd0, ST_OK); directed_known[19] = 1'b1;
    directed_req[20] = req(3'd6, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    directed_rsp[20] = rsp(32'sd0, 32'sd0, ST_OK); directed_known[20] = 1'b1;
    directed_req[21] = req(3'd7, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
    directed_rsp[21] = rsp(32'sd0, 32'sd0, ST_OK); directed_known[21] = 1'b1;
    directed_req[22] = req(ACT_DIV, 32'sd1, 32'sd1, -32'sd1, 32'sd0);
    directed_req[23] = req(ACT_MUL, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
  endtask

  // Offers one request and holds it until accepted.
  task automatic send_request(input cau_req_t r, input bit may_idle);
    while (may_idle && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    result_queue.push_back(complex_result(r));
  endtask

  initial begin
    int k;
    cau_rsp_t known;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    stimulus_done = 1'b0;
    failed = 1'b0;
    mismatches = 0;
    build_table();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (k = 0; k < DIRECTED_ITEMS; k++) begin
      send_request(directed_req[k], 1'b1);
      if (directed_known[k]) begin
        known = result_queue[$];
        if (known != directed_rsp[k]) begin
          failed = 1'b1;
          $display("Table row %0d disagrees with the predictor.", k);
        end
      end
    end
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      send_request(random_request(), !(k >= 200 && k < 350));
    end
    in_valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Result side: random stalls, one long hold-off, and a quiet stretch.
  initial begin
    int cycle;
    out_stall = 1'b0;
    hold_off = 1'b0;
    cycle = 0;
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle == 300) hold_off = 1'b1;
      if (cycle == 600) hold_off = 1'b0;
      if (hold_off) out_stall <= 1'b1;
      else if (cycle > 700 && cycle < 1000) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 99) < 32);
    end
  end

  always @(posedge clk) begin
    cau_rsp_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (result_queue.size() == 0) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %p.", out_data);
        end else begin
          want = result_queue.pop_front();
          if (out_data.z_re !== want.z_re || out_data.z_im !== want.z_im ||
              out_data.status !== want.status) begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch: expected %p, got %p.", want, out_data);
            end
          end
        end
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  initial begin
    int settle;
    settle = 0;
    while (!(stimulus_done && result_queue.size() == 0) && idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
    end else begin
      while (settle < LATENCY + 20) begin
        @(posedge clk);
        settle++;
      end
      if (!failed && result_queue.size() == 0) begin
        $display("TB_OK");
      end else begin
        $display("TB_ERROR");
      end
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+sv
sv/cau_pkg.sv
sv/complex_arith_unit_core.sv
test/complex_arith_unit_core_test.sv
